/* hdl/ieqd_pkg.sv */
// Package for the input event queue device: sequencer and source types,
// operation codes, register indexes, page constants and the device name table.
// Used by the top level, the checker and the testbench; depends on nothing.
package ieqd_pkg;

	localparam int RING_WORDS_DEF = 1024;

	typedef enum logic [1:0] {
		OP_RAW     = 2'd0,
		OP_POINTER = 2'd1,
		OP_READ    = 2'd2,
		OP_WRITE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_TOUCH      = 2'd0,
		CFG_TRACKBALL  = 2'd1,
		CFG_MULTITOUCH = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_INIT     = 2'd0,
		PH_BUFFERED = 2'd1,
		PH_LIVE     = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		SRC_RAW   = 2'd0,
		SRC_TOUCH = 2'd1,
		SRC_TRACK = 2'd2
	} src_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_PUSH = 5'b00100,
		ST_POP  = 5'b01000,
		ST_DONE = 5'b10000
	} seq_t;

	// Register window offsets.
	localparam logic [11:0] ADDR_POP  = 12'd0;
	localparam logic [11:0] ADDR_LEN  = 12'd4;
	localparam logic [11:0] ADDR_DATA = 12'd8;

	// Page selectors.
	localparam logic [31:0] PAGE_DEVNAME = 32'h0000_0000;
	localparam logic [31:0] PAGE_ABS     = 32'h0002_0003;

	// Page lengths in bytes.
	localparam logic [10:0] NAME_LEN       = 11'd7;
	localparam logic [10:0] ABS_LEN_SINGLE = 11'(4 * 3 * 4);
	localparam logic [10:0] ABS_LEN_MULTI  = 11'(4 * 'h3f * 4);

	// Event types and codes.
	localparam logic [31:0] EV_SYN    = 32'd0;
	localparam logic [31:0] EV_KEY    = 32'd1;
	localparam logic [31:0] EV_REL    = 32'd2;
	localparam logic [31:0] EV_ABS    = 32'd3;
	localparam logic [31:0] CODE_X    = 32'd0;
	localparam logic [31:0] CODE_Y    = 32'd1;
	localparam logic [31:0] CODE_Z    = 32'd2;
	localparam logic [31:0] KEY_TOUCH = 32'h0000_014a;
	localparam logic [31:0] AXIS_MAX  = 32'h0000_7fff;

	// Seven ASCII bytes of the device name.
	function automatic logic [7:0] name_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'h71;
			3'd1: b = 8'h77;
			3'd2: b = 8'h65;
			3'd3: b = 8'h72;
			3'd4: b = 8'h74;
			3'd5: b = 8'h79;
			3'd6: b = 8'h32;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* hdl/ieqd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing.
module ieqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/input_event_queue_device.sv */
// Input event queue device: an accepted transaction goes from IDLE to EXEC; events that store
// triples then run PUSH, where the single RAM write port stores one ring word per cycle (a
// dropped triple is skipped unwritten), and a pop of a non-empty ring runs POP for the
// registered RAM read. Every transaction ends in DONE, which loads the result register once it
// is free; one transaction at a time. Reset (arst_n low) empties the ring, clears phase, page and
// interrupt and selects touch present; ring contents are kept. Uses ieqd_pkg, ieqd_ram.
module input_event_queue_device
	import ieqd_pkg::*;
#(
	parameter int RING_WORDS = RING_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	// Input channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [11:0] bus_address,
	input  logic [31:0] write_value,
	input  logic [4:0]  event_type,
	input  logic [9:0]  event_code,
	input  logic [31:0] event_value,
	input  logic [31:0] pointer_x,
	input  logic [31:0] pointer_y,
	input  logic [31:0] pointer_z,
	input  logic        pointer_pressed,
	// Output channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        irq_level,
	output logic [2:0]  dropped_count
);

	localparam int PW = $clog2(RING_WORDS);
	localparam logic [PW-1:0] LAST_IDX = PW'(RING_WORDS - 1);
	localparam logic [PW:0]   RW_EXT   = (PW + 1)'(RING_WORDS);
	localparam logic [PW+1:0] RW_CMP   = (PW + 2)'(RING_WORDS);

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + PW'(1);
	endfunction

	// Control state.
	seq_t          st_q;
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_q;
	phase_t        phase_q;
	logic [31:0]   page_q;
	logic          irq_q;
	logic          touch_q;
	logic          track_q;
	logic          multi_q;
	src_t          src_q;
	logic [2:0]    trip_q;
	logic [2:0]    ntrip_q;
	logic [1:0]    word_q;
	logic [2:0]    drop_q;
	logic [31:0]   rd_q;
	logic          out_valid_q;

	// Transaction payload captured at acceptance.
	op_t           op_q;
	logic [11:0]   addr_q;
	logic [31:0]   wval_q;
	logic [4:0]    etype_q;
	logic [9:0]    ecode_q;
	logic [31:0]   evalue_q;
	logic [31:0]   px_q;
	logic [31:0]   py_q;
	logic [31:0]   pz_q;
	logic          pp_q;

	// Result register.
	logic [31:0]   read_data_q;
	logic          irq_level_q;
	logic [2:0]    dropped_q;

	// RAM interface.
	logic          ram_we;
	logic          ram_re;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;

	// Combinational helpers.
	logic          has_touch;
	logic          ring_empty;
	logic [PW:0]   used_w;
	logic          full_w;
	logic [31:0]   t_w;
	logic [31:0]   c_w;
	logic [31:0]   v_w;
	logic [10:0]   pg_len_w;
	logic [11:0]   data_n;
	logic [31:0]   page_word;
	logic          out_free;
	logic          last_trip;
	logic [PW-1:0] rp_next;

	assign in_ready      = (st_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign irq_level     = irq_level_q;
	assign dropped_count = dropped_q;

	assign has_touch  = touch_q | multi_q;
	assign ring_empty = (rp_q == wp_q);
	assign out_free   = !out_valid_q || out_ready;
	assign last_trip  = (trip_q == ntrip_q - 3'd1);
	assign rp_next    = ring_next(rp_q);

	// Fill level of the ring. A triple goes in only if four words are free, so the
	// write pointer never catches up with the read pointer.
	always_comb begin
		if (wp_q >= rp_q) begin
			used_w = {1'b0, wp_q} - {1'b0, rp_q};
		end else begin
			used_w = {1'b0, wp_q} + RW_EXT - {1'b0, rp_q};
		end
		full_w = ({1'b0, used_w} + (PW + 2)'(3)) >= RW_CMP;
	end

	// The triple that the current push step stores.
	always_comb begin
		t_w = EV_SYN;
		c_w = 32'd0;
		v_w = 32'd0;
		unique case (src_q)
			SRC_RAW: begin
				t_w = 32'(etype_q);
				c_w = 32'(ecode_q);
				v_w = evalue_q;
			end
			SRC_TOUCH: begin
				unique case (trip_q)
					3'd0: begin t_w = EV_ABS; c_w = CODE_X; v_w = px_q; end
					3'd1: begin t_w = EV_ABS; c_w = CODE_Y; v_w = py_q; end
					3'd2: begin t_w = EV_ABS; c_w = CODE_Z; v_w = pz_q; end
					3'd3: begin t_w = EV_KEY; c_w = KEY_TOUCH; v_w = 32'(pp_q); end
					default: begin t_w = EV_SYN; c_w = 32'd0; v_w = 32'd0; end
				endcase
			end
			SRC_TRACK: begin
				unique case (trip_q)
					3'd0: begin t_w = EV_REL; c_w = CODE_X; v_w = px_q; end
					3'd1: begin t_w = EV_REL; c_w = CODE_Y; v_w = py_q; end
					default: begin t_w = EV_SYN; c_w = 32'd0; v_w = 32'd0; end
				endcase
			end
			default: begin
				t_w = EV_SYN;
			end
		endcase
		unique case (word_q)
			2'd0: ram_wdata = t_w;
			2'd1: ram_wdata = c_w;
			default: ram_wdata = v_w;
		endcase
	end

	// Descriptive pages: length and data bytes or words.
	always_comb begin
		if (page_q == PAGE_DEVNAME) begin
			pg_len_w = NAME_LEN;
		end else if (page_q == PAGE_ABS && has_touch) begin
			pg_len_w = multi_q ? ABS_LEN_MULTI : ABS_LEN_SINGLE;
		end else begin
			pg_len_w = '0;
		end
		data_n = addr_q - ADDR_DATA;
		page_word = 32'd0;
		if (data_n < {1'b0, pg_len_w}) begin
			if (page_q == PAGE_DEVNAME) begin
				page_word = 32'(name_byte(data_n[2:0]));
			end else if (page_q == PAGE_ABS) begin
				if (data_n[11:2] == 10'd1 || data_n[11:2] == 10'd5) begin
					page_word = AXIS_MAX;
				end else if (data_n[11:2] == 10'd9) begin
					page_word = 32'd1;
				end
			end
		end
	end

	// A ring word is written in each push step, unless the triple is dropped.
	assign ram_we = (st_q == ST_PUSH) && !(word_q == 2'd0 && full_w);
	assign ram_re = (st_q == ST_EXEC) && (op_q == OP_READ) && (addr_q == ADDR_POP) && !ring_empty;

	ieqd_ram #(
		.WIDTH (32),
		.DEPTH (RING_WORDS)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	// Transaction payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= op_t'(op);
			addr_q   <= bus_address;
			wval_q   <= write_value;
			etype_q  <= event_type;
			ecode_q  <= event_code;
			evalue_q <= event_value;
			px_q     <= pointer_x;
			py_q     <= pointer_y;
			pz_q     <= pointer_z;
			pp_q     <= pointer_pressed;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_q <= 1'b1;
			track_q <= 1'b0;
			multi_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TOUCH:      touch_q <= cfg_data;
				CFG_TRACKBALL:  track_q <= cfg_data;
				CFG_MULTITOUCH: multi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: decode, push words, pop a word, then hand the result to the output
	// register once it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			phase_q     <= PH_INIT;
			page_q      <= '0;
			irq_q       <= 1'b0;
			src_q       <= SRC_RAW;
			trip_q      <= '0;
			ntrip_q     <= '0;
			word_q      <= '0;
			drop_q      <= '0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
			read_data_q <= '0;
			irq_level_q <= 1'b0;
			dropped_q   <= '0;
		end else begin
			// A taken result leaves the output register unless a new one replaces it now.
			if (out_valid_q && out_ready && st_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						rd_q   <= '0;
						drop_q <= '0;
						trip_q <= '0;
						word_q <= '0;
						st_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (op_q)
						OP_RAW: begin
							src_q   <= SRC_RAW;
							ntrip_q <= 3'd1;
							st_q    <= ST_PUSH;
						end
						OP_POINTER: begin
							if (has_touch) begin
								src_q   <= SRC_TOUCH;
								ntrip_q <= 3'd5;
								st_q    <= ST_PUSH;
							end else if (track_q) begin
								src_q   <= SRC_TRACK;
								ntrip_q <= 3'd3;
								st_q    <= ST_PUSH;
							end else begin
								st_q <= ST_DONE;
							end
						end
						OP_READ: begin
							if (addr_q == ADDR_POP) begin
								// An empty ring answers the pop with zero.
								st_q <= ring_empty ? ST_DONE : ST_POP;
							end else begin
								st_q <= ST_DONE;
								if (addr_q == ADDR_LEN) begin
									// Reading the length of the absolute-data page makes the
									// driver live.
									if (page_q == PAGE_ABS) begin
										if (phase_q == PH_BUFFERED) begin
											irq_q <= 1'b1;
										end
										phase_q <= PH_LIVE;
									end
									rd_q <= 32'(pg_len_w);
								end else if (addr_q >= ADDR_DATA) begin
									rd_q <= page_word;
								end
							end
						end
						OP_WRITE: begin
							st_q <= ST_DONE;
							if (addr_q == ADDR_POP) begin
								page_q <= wval_q;
							end
						end
						default: st_q <= ST_DONE;
					endcase
				end
				ST_PUSH: begin
					if (word_q == 2'd0 && full_w) begin
						drop_q <= drop_q + 3'd1;
						trip_q <= trip_q + 3'd1;
						if (last_trip) begin
							st_q <= ST_DONE;
						end
					end else begin
						// The first word into an empty ring wakes a live driver.
						if (word_q == 2'd0 && ring_empty) begin
							if (phase_q == PH_LIVE) begin
								irq_q <= 1'b1;
							end else begin
								phase_q <= PH_BUFFERED;
							end
						end
						wp_q <= ring_next(wp_q);
						if (word_q == 2'd2) begin
							word_q <= '0;
							trip_q <= trip_q + 3'd1;
							if (last_trip) begin
								st_q <= ST_DONE;
							end
						end else begin
							word_q <= word_q + 2'd1;
						end
					end
				end
				ST_POP: begin
					rd_q <= ram_rdata;
					rp_q <= rp_next;
					if (rp_next == wp_q) begin
						irq_q <= 1'b0;
					end
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						read_data_q <= rd_q;
						irq_level_q <= irq_q;
						dropped_q   <= drop_q;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// A stored word must never move the write pointer onto the read pointer.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ring_next(wp_q) != rp_q))
		else $error("ring write overtakes read pointer");

	// The ring is only written while a push is in progress.
	a_write_in_push: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (st_q == ST_PUSH))
		else $error("ring write outside push");

	// A pop always advances the read pointer by one entry.
	a_pop_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_POP) |=> (rp_q == ring_next($past(rp_q))))
		else $error("pop did not advance read pointer");

	// No item drops more triples than a touch pointer event carries.
	a_drop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (dropped_count <= 3'd5))
		else $error("dropped count out of range");

endmodule

/* tb/sv/ieqd_checker.sv */
// Result checker for the input event queue device: watches the configuration port and both
// channels, predicts every transaction's result and compares it field by field.
// Depends on ieqd_pkg.
module ieqd_checker
	import ieqd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [11:0] bus_address,
	input  logic [31:0] write_value,
	input  logic [4:0]  event_type,
	input  logic [9:0]  event_code,
	input  logic [31:0] event_value,
	input  logic [31:0] pointer_x,
	input  logic [31:0] pointer_y,
	input  logic [31:0] pointer_z,
	input  logic        pointer_pressed,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] read_data,
	input  logic        irq_level,
	input  logic [2:0]  dropped_count,
	output int          fail_count,
	output int          outstanding,
	output int          dropped_total
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = RING_WORDS_DEF;
	localparam int REPORT_LIMIT = 10;
	// Device name, first character in the top byte.
	localparam logic [55:0] NAME_BYTES = 56'h71_77_65_72_74_79_32;

	typedef struct packed {
		logic [31:0] rdata;
		logic        irq;
		logic [2:0]  dropped;
	} queue_result_t;

	logic [31:0] ring_words [DEPTH];
	int head_idx;
	int tail_idx;
	phase_t drv_phase;
	logic [31:0] page_sel;
	logic irq_pred;
	logic cfg_touch;
	logic cfg_track;
	logic cfg_multi;
	queue_result_t result_fifo [$];
	int reported;

	// A triple goes in only while four words are free, so the ring never wraps onto itself.
	function automatic logic [2:0] store_triple(input logic [31:0] w_type, w_code, w_value);
		int used;
		used = (tail_idx - head_idx + DEPTH) % DEPTH;
		if (used + 3 >= DEPTH)
			return 3'd1;
		if (head_idx == tail_idx) begin
			if (drv_phase == PH_LIVE)
				irq_pred = 1'b1;
			else
				drv_phase = PH_BUFFERED;
		end
		ring_words[tail_idx] = w_type;
		ring_words[(tail_idx + 1) % DEPTH] = w_code;
		ring_words[(tail_idx + 2) % DEPTH] = w_value;
		tail_idx = (tail_idx + 3) % DEPTH;
		return 3'd0;
	endfunction

	function automatic logic [31:0] take_word();
		logic [31:0] w;
		if (head_idx == tail_idx)
			return '0;
		w = ring_words[head_idx];
		head_idx = (head_idx + 1) % DEPTH;
		if (head_idx == tail_idx)
			irq_pred = 1'b0;
		return w;
	endfunction

	function automatic logic [31:0] len_of_page();
		if (page_sel == PAGE_DEVNAME)
			return 32'd7;
		// Three or sixty-three entries of four words, four bytes each.
		if (page_sel == PAGE_ABS && (cfg_touch || cfg_multi))
			return cfg_multi ? 32'd1008 : 32'd48;
		return '0;
	endfunction

	function automatic logic [31:0] page_value(input int n);
		int word_idx;
		if (n >= len_of_page())
			return '0;
		if (page_sel == PAGE_DEVNAME)
			return {24'd0, NAME_BYTES[8 * (6 - n) +: 8]};
		word_idx = n / 4;
		if (word_idx == 1 || word_idx == 5)
			return 32'h0000_7fff;
		if (word_idx == 9)
			return 32'd1;
		return '0;
	endfunction

	function automatic queue_result_t predict_result();
		queue_result_t r;
		r = '0;
		case (op_t'(op))
			OP_RAW: begin
				r.dropped = store_triple({27'd0, event_type}, {22'd0, event_code}, event_value);
			end
			OP_POINTER: begin
				if (cfg_touch || cfg_multi) begin
					r.dropped += store_triple(EV_ABS, CODE_X, pointer_x);
					r.dropped += store_triple(EV_ABS, CODE_Y, pointer_y);
					r.dropped += store_triple(EV_ABS, CODE_Z, pointer_z);
					r.dropped += store_triple(EV_KEY, KEY_TOUCH, {31'd0, pointer_pressed});
					r.dropped += store_triple(EV_SYN, 32'd0, 32'd0);
				end else if (cfg_track) begin
					r.dropped += store_triple(EV_REL, CODE_X, pointer_x);
					r.dropped += store_triple(EV_REL, CODE_Y, pointer_y);
					r.dropped += store_triple(EV_SYN, 32'd0, 32'd0);
				end
			end
			OP_READ: begin
				if (bus_address == ADDR_POP) begin
					r.rdata = take_word();
				end else if (bus_address == ADDR_LEN) begin
					// Reading the length of the absolute-data page is what makes the driver live.
					if (page_sel == PAGE_ABS) begin
						if (drv_phase == PH_BUFFERED)
							irq_pred = 1'b1;
						drv_phase = PH_LIVE;
					end
					r.rdata = len_of_page();
				end else if (bus_address >= ADDR_DATA) begin
					r.rdata = page_value(int'(bus_address - ADDR_DATA));
				end
			end
			OP_WRITE: begin
				if (bus_address == ADDR_POP)
					page_sel = write_value;
			end
			default: ;
		endcase
		r.irq = irq_pred;
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want, got);
		if (want !== got) begin
			fail_count++;
			if (reported < REPORT_LIMIT) begin
				reported++;
				$display("MISMATCH %s: expected 0x%08h, got 0x%08h", field, want, got);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			head_idx = 0;
			tail_idx = 0;
			drv_phase = PH_INIT;
			page_sel = '0;
			irq_pred = 1'b0;
			cfg_touch = 1'b1;
			cfg_track = 1'b0;
			cfg_multi = 1'b0;
			result_fifo.delete();
			fail_count = 0;
			reported = 0;
			dropped_total = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TOUCH:      cfg_touch = cfg_data;
					CFG_TRACKBALL:  cfg_track = cfg_data;
					CFG_MULTITOUCH: cfg_multi = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				want = predict_result();
				dropped_total += int'(want.dropped);
				result_fifo.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (result_fifo.size() == 0) begin
					fail_count++;
					if (reported < REPORT_LIMIT) begin
						reported++;
						$display("UNEXPECTED result: read_data 0x%08h irq %0b dropped %0d",
							read_data, irq_level, dropped_count);
					end
				end else begin
					want = result_fifo.pop_front();
					check_field("read_data", want.rdata, read_data);
					check_field("irq_level", {31'd0, want.irq}, {31'd0, irq_level});
					check_field("dropped_count", {29'd0, want.dropped}, {29'd0, dropped_count});
				end
			end
			outstanding <= result_fifo.size();
		end
	end

endmodule

/* tb/sv/tb_input_event_queue_device.sv */
// Testbench top for the input event queue device: clock, reset, stimulus and verdict.
// Instantiates the device and ieqd_checker; depends on ieqd_pkg.
module tb_input_event_queue_device;
	import ieqd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// The slack after draining covers the longest transaction, a touch pointer event, with margin.
	localparam int DRAIN_SLACK = 24;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT = 500000;

	// A single stimulus transaction. Fields that the operation does not use still carry
	// random values so that every input bit toggles.
	typedef struct {
		op_t         op;
		logic [11:0] addr;
		logic [31:0] wval;
		logic [4:0]  etype;
		logic [9:0]  ecode;
		logic [31:0] evalue;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic        pressed;
	} ev_item_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = '0;
	logic [11:0] bus_address = '0;
	logic [31:0] write_value = '0;
	logic [4:0]  event_type = '0;
	logic [9:0]  event_code = '0;
	logic [31:0] event_value = '0;
	logic [31:0] pointer_x = '0;
	logic [31:0] pointer_y = '0;
	logic [31:0] pointer_z = '0;
	logic        pointer_pressed = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] read_data;
	logic        irq_level;
	logic [2:0]  dropped_count;

	int fail_count;
	int results_outstanding;
	int dropped_total;
	int items_sent = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	logic hold_off_request = 1'b0;
	logic hold_off_done = 1'b0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	input_event_queue_device u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.bus_address    (bus_address),
		.write_value    (write_value),
		.event_type     (event_type),
		.event_code     (event_code),
		.event_value    (event_value),
		.pointer_x      (pointer_x),
		.pointer_y      (pointer_y),
		.pointer_z      (pointer_z),
		.pointer_pressed(pointer_pressed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_data      (read_data),
		.irq_level      (irq_level),
		.dropped_count  (dropped_count)
	);

	ieqd_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.bus_address    (bus_address),
		.write_value    (write_value),
		.event_type     (event_type),
		.event_code     (event_code),
		.event_value    (event_value),
		.pointer_x      (pointer_x),
		.pointer_y      (pointer_y),
		.pointer_z      (pointer_z),
		.pointer_pressed(pointer_pressed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_data      (read_data),
		.irq_level      (irq_level),
		.dropped_count  (dropped_count),
		.fail_count     (fail_count),
		.outstanding    (results_outstanding),
		.dropped_total  (dropped_total)
	);

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, results_outstanding);
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side. Normally out_ready follows the stall percentage of the current phase.
	// On request it holds off once for a long stretch, counted here, so that the device has
	// to keep a finished result and stop taking new transactions.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_request && !hold_off_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done <= 1'b1;
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Mostly plain random words, with the signed and unsigned extremes mixed in.
	function automatic logic [31:0] any_word();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic ev_item_t base_event();
		ev_item_t it;
		it.op = OP_READ;
		it.addr = ADDR_POP;
		it.wval = any_word();
		it.etype = 5'($urandom_range(31));
		it.ecode = 10'($urandom_range(1023));
		it.evalue = any_word();
		it.px = any_word();
		it.py = any_word();
		it.pz = any_word();
		it.pressed = 1'($urandom_range(1));
		return it;
	endfunction

	// Random transaction. pop_pct sets how much of the traffic drains the ring; in fill
	// mode almost everything else is a pointer event so that the ring runs full.
	function automatic ev_item_t random_event(input int pop_pct, input bit fill);
		ev_item_t it;
		int r;
		it = base_event();
		r = $urandom_range(99);
		if (r < pop_pct) begin
			it.op = OP_READ;
			it.addr = ADDR_POP;
		end else if (fill) begin
			it.op = ($urandom_range(99) < 85) ? OP_POINTER : OP_RAW;
		end else begin
			r = $urandom_range(99);
			if (r < 25) begin
				it.op = OP_RAW;
			end else if (r < 45) begin
				it.op = OP_POINTER;
			end else if (r < 72) begin
				it.op = OP_READ;
				case ($urandom_range(3))
					0: it.addr = ADDR_LEN;
					1: it.addr = ADDR_DATA + 12'($urandom_range(9));
					2: it.addr = ADDR_DATA + 12'($urandom_range(1020));
					default: it.addr = $urandom_range(1) ? 12'($urandom_range(1, 7))
						: 12'($urandom_range(4095));
				endcase
			end else if (r < 92) begin
				// Page select: mostly the two real pages, sometimes a neighbor or junk.
				it.op = OP_WRITE;
				it.addr = ADDR_POP;
				r = $urandom_range(99);
				if (r < 35)
					it.wval = PAGE_DEVNAME;
				else if (r < 70)
					it.wval = PAGE_ABS;
				else if (r < 85)
					it.wval = ($urandom_range(1) ? 32'h0002_0000 : 32'h0001_0000) | $urandom_range(7);
			end else begin
				it.op = OP_WRITE;
				it.addr = 12'($urandom_range(4095));
			end
		end
		return it;
	endfunction

	// Offer one transaction and return in the time step where it is accepted. The caller
	// must drive in_valid again in that same step, by sending or by going idle.
	task automatic send_event(input ev_item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		bus_address <= it.addr;
		write_value <= it.wval;
		event_type <= it.etype;
		event_code <= it.ecode;
		event_value <= it.evalue;
		pointer_x <= it.px;
		pointer_y <= it.py;
		pointer_z <= it.pz;
		pointer_pressed <= it.pressed;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	task automatic send_bus(input op_t o, input logic [11:0] a, input logic [31:0] v);
		ev_item_t it;
		it = base_event();
		it.op = o;
		it.addr = a;
		it.wval = v;
		send_event(it);
	endtask

	// Stop offering and wait until every predicted result has come back, plus slack.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_outstanding != 0);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges; only called while the device is idle.
	task automatic write_settings(input logic touch, trackball, multitouch);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TOUCH;
		cfg_data <= touch;
		@(posedge clk);
		cfg_index <= CFG_TRACKBALL;
		cfg_data <= trackball;
		@(posedge clk);
		cfg_index <= CFG_MULTITOUCH;
		cfg_data <= multitouch;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic touch, trackball, multitouch,
		input int idle_pct, stall_pct, n_items, pop_pct, input bit fill, hold_off, pause_mid);
		wait_drained();
		write_settings(touch, trackball, multitouch);
		sender_idle_pct = idle_pct;
		receiver_stall_pct <= stall_pct;
		for (int i = 0; i < n_items; i++) begin
			if (hold_off && i == 10)
				hold_off_request <= 1'b1;
			if (pause_mid && i == n_items / 2)
				wait_drained();
			send_event(random_event(pop_pct, fill));
		end
	endtask

	initial begin
		ev_item_t it;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset configuration (touch present), no idling on either side.
		// Name page: length, first and last byte, and the first offset past the end.
		send_bus(OP_READ, ADDR_LEN, '0);
		send_bus(OP_READ, ADDR_DATA, '0);
		send_bus(OP_READ, ADDR_DATA + 12'd6, '0);
		send_bus(OP_READ, ADDR_DATA + 12'd7, '0);
		// Odd offsets read as zero, and a pop of the empty ring returns zero.
		send_bus(OP_READ, 12'd3, '0);
		send_bus(OP_READ, 12'd5, '0);
		send_bus(OP_READ, ADDR_POP, '0);
		// A raw event with the widest type and code; the driver is not live yet,
		// so this only moves it to the buffered phase.
		it = base_event();
		it.op = OP_RAW;
		it.etype = 5'd31;
		it.ecode = 10'd1023;
		it.evalue = 32'h8000_0000;
		send_event(it);
		// A write away from offset 0 is ignored.
		send_bus(OP_WRITE, 12'd12, 32'hffff_ffff);
		// Select the absolute-data page; reading its length raises the interrupt
		// (buffered data) and makes the driver live.
		send_bus(OP_WRITE, ADDR_POP, PAGE_ABS);
		send_bus(OP_READ, ADDR_LEN, '0);
		send_bus(OP_READ, ADDR_DATA + 12'd4, '0);
		send_bus(OP_READ, ADDR_DATA + 12'd36, '0);
		send_bus(OP_READ, ADDR_DATA + 12'd47, '0);
		send_bus(OP_READ, ADDR_DATA + 12'd48, '0);
		// Drain the triple; the last pop lowers the interrupt.
		repeat (3) send_bus(OP_READ, ADDR_POP, '0);
		// With the driver live, an event into the empty ring raises the interrupt at once.
		it = base_event();
		it.op = OP_RAW;
		it.etype = 5'd0;
		it.ecode = 10'd0;
		it.evalue = 32'h7fff_ffff;
		send_event(it);
		it = base_event();
		it.op = OP_POINTER;
		it.px = 32'h7fff_ffff;
		it.py = 32'h8000_0000;
		it.pz = 32'hffff_ffff;
		it.pressed = 1'b1;
		send_event(it);
		// A capability page has length zero and no data.
		send_bus(OP_WRITE, ADDR_POP, 32'h0001_0000);
		send_bus(OP_READ, ADDR_LEN, '0);
		send_bus(OP_READ, ADDR_DATA, '0);
		send_bus(OP_WRITE, ADDR_POP, PAGE_DEVNAME);

		// Random phases: touch, trackball, neither, all, multitouch alone and mixtures,
		// each with its own idling pattern. The first phase carries the long receiver
		// hold-off, the fifth a pause until every result is back, the last fills the ring.
		run_phase(1'b1, 1'b0, 1'b0,  0,  0, 85, 45, 1'b0, 1'b1, 1'b0);
		run_phase(1'b0, 1'b1, 1'b0, 88,  0, 75, 50, 1'b0, 1'b0, 1'b0);
		run_phase(1'b0, 1'b0, 1'b0,  0, 88, 65, 55, 1'b0, 1'b0, 1'b0);
		run_phase(1'b1, 1'b1, 1'b1, 21, 21, 75, 40, 1'b0, 1'b0, 1'b0);
		run_phase(1'b0, 1'b0, 1'b1,  0,  0, 70, 55, 1'b0, 1'b0, 1'b1);
		run_phase(1'b1, 1'b0, 1'b1, 88,  0, 70, 50, 1'b0, 1'b0, 1'b0);
		run_phase(1'b0, 1'b1, 1'b1,  0, 88, 60, 50, 1'b0, 1'b0, 1'b0);
		run_phase(1'b1, 1'b0, 1'b0, 21, 21, 120, 8, 1'b1, 1'b0, 1'b0);
		wait_drained();

		$display("Sent %0d transactions across eight device configurations; %0d triples dropped",
			items_sent, dropped_total);
		$display("on a full ring, under no idling, sender gaps, receiver stalls and one long hold-off.");
		if (fail_count == 0 && results_outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
